[hdl/pmtp_pkg.sv]
package pmtp_pkg;

    // field widths fixed by the stream format
    localparam int COORD_W  = 32;
    localparam int DIFF_W   = COORD_W + 1;   // difference of two coordinates
    localparam int ACC_W    = COORD_W + 3;   // partial product plus one addend
    localparam int REM_W    = COORD_W + 1;   // shifted remainder
    localparam int TDATA_W  = 3 * COORD_W;

    localparam int FACTOR_BITS_DEF = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_EMIT
    } t_state;

    // start strobe and step enable toward the serial units
    typedef struct packed {
        logic start;
        logic step;
    } t_ser_ctl;

endpackage

[hdl/polyline_measure_to_point.sv]
// Point at a target measure along a measured polyline. Vertices arrive one per
// beat on the slave stream (x, y, measure in tdata, tlast on the final vertex);
// the target measure is written on the config channel before a polyline starts.
// At the first vertex after the first whose measure exceeds the target, the
// block interpolates between it and the previous vertex and holds that point;
// the final vertex yields one beat on the master stream with tuser = found and
// the point (zeros when not found). The crossing vertex first runs the
// restoring divider, which forms the factor one bit per cycle, then the three
// shift-add multipliers, which consume it one bit per cycle. A final vertex
// goes through the emit state to load the output register, and waits
// there if the previous result beat has not been taken. At most one crossing
// is computed per polyline.
module polyline_measure_to_point #(
    parameter int FACTOR_BITS = pmtp_pkg::FACTOR_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // config: target measure, signed Q23.8
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pmtp_pkg::COORD_W-1:0]          i_cfg_data,
    // tdata: point_x [31:0], point_y [63:32], point_measure [95:64]
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [pmtp_pkg::TDATA_W-1:0]          s_axis_tdata,
    input  logic                                  s_axis_tlast,   // last_point
    // tdata: out_x [31:0], out_y [63:32], out_measure [95:64]
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [pmtp_pkg::TDATA_W-1:0]          m_axis_tdata,
    output logic                                  m_axis_tuser    // found
);

    localparam int CW  = pmtp_pkg::COORD_W;
    localparam int CNT_W = $clog2(FACTOR_BITS);

    pmtp_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic signed [CW-1:0] r_target;
    logic                 r_expect_first;
    logic signed [CW-1:0] r_first_m;
    logic signed [CW-1:0] r_prev_x, r_prev_y, r_prev_m;
    logic                 r_cross;      // crossing latched for this polyline
    logic                 r_last_pend;  // crossing vertex was also the last one
    logic                 r_ovalid;
    logic                 r_ofound;
    logic [pmtp_pkg::TDATA_W-1:0] r_odata;

    logic signed [CW-1:0] in_x, in_y, in_m;
    logic                 in_acc;
    logic                 is_cross;
    logic                 cnt_end;
    logic                 emit_go;
    logic                 hit;
    logic [FACTOR_BITS-1:0] quot;
    logic [CW-1:0]        lerp_x, lerp_y, lerp_m;

    pmtp_pkg::t_ser_ctl div_ctl, mul_ctl;

    assign in_x = s_axis_tdata[CW-1:0];
    assign in_y = s_axis_tdata[2*CW-1:CW];
    assign in_m = s_axis_tdata[3*CW-1:2*CW];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == pmtp_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_cross      = !r_expect_first && !r_cross && (in_m > r_target);
    assign cnt_end       = (r_cnt == CNT_W'(FACTOR_BITS - 1));
    assign emit_go       = !r_ovalid || m_axis_tready;
    // range test uses the final vertex measure, now in r_prev_m
    assign hit = r_cross && (r_target >= r_first_m) && (r_target <= r_prev_m);

    // next state and unit control
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        div_ctl.start = 1'b0;
        div_ctl.step  = 1'b0;
        mul_ctl.start = 1'b0;
        mul_ctl.step  = 1'b0;
        case (r_state)
            pmtp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (is_cross) begin
                        div_ctl.start = 1'b1;
                        mul_ctl.start = 1'b1;
                        n_cnt         = '0;
                        n_state       = pmtp_pkg::ST_DIV;
                    end else if (s_axis_tlast) begin
                        n_state = pmtp_pkg::ST_EMIT;
                    end
                end
            end
            pmtp_pkg::ST_DIV: begin
                div_ctl.step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (cnt_end) begin
                    n_cnt   = '0;
                    n_state = pmtp_pkg::ST_MUL;
                end
            end
            pmtp_pkg::ST_MUL: begin
                mul_ctl.step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (cnt_end) begin
                    n_cnt   = '0;
                    n_state = r_last_pend ? pmtp_pkg::ST_EMIT : pmtp_pkg::ST_IDLE;
                end
            end
            pmtp_pkg::ST_EMIT: begin
                if (emit_go) begin
                    n_state = pmtp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pmtp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmtp_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // polyline state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target       <= '0;
            r_expect_first <= 1'b1;
            r_first_m      <= '0;
            r_prev_x       <= '0;
            r_prev_y       <= '0;
            r_prev_m       <= '0;
            r_cross        <= 1'b0;
            r_last_pend    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_target <= i_cfg_data;
            end
            if (in_acc) begin
                if (r_expect_first) begin
                    r_first_m      <= in_m;
                    r_expect_first <= 1'b0;
                end
                if (is_cross) begin
                    r_cross <= 1'b1;
                end
                r_prev_x    <= in_x;
                r_prev_y    <= in_y;
                r_prev_m    <= in_m;
                r_last_pend <= s_axis_tlast;
            end
            if (r_state == pmtp_pkg::ST_EMIT && emit_go) begin
                r_expect_first <= 1'b1;
                r_cross        <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == pmtp_pkg::ST_EMIT && emit_go) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pmtp_pkg::ST_EMIT && emit_go) begin
            r_ofound <= hit;
            r_odata  <= hit ? {lerp_m, lerp_y, lerp_x} : '0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ofound;

    pmtp_div #(
        .FACTOR_BITS(FACTOR_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_ctl  (div_ctl),
        .i_num  (pmtp_pkg::DIFF_W'(r_target) - pmtp_pkg::DIFF_W'(r_prev_m)),
        .i_den  (pmtp_pkg::DIFF_W'(in_m) - pmtp_pkg::DIFF_W'(r_prev_m)),
        .o_quot (quot)
    );

    pmtp_lerp u_lerp_x (
        .i_clk   (i_clk),
        .i_ctl   (mul_ctl),
        .i_bit   (quot[r_cnt]),
        .i_base  (r_prev_x),
        .i_diff  (pmtp_pkg::DIFF_W'(in_x) - pmtp_pkg::DIFF_W'(r_prev_x)),
        .o_value (lerp_x)
    );

    pmtp_lerp u_lerp_y (
        .i_clk   (i_clk),
        .i_ctl   (mul_ctl),
        .i_bit   (quot[r_cnt]),
        .i_base  (r_prev_y),
        .i_diff  (pmtp_pkg::DIFF_W'(in_y) - pmtp_pkg::DIFF_W'(r_prev_y)),
        .o_value (lerp_y)
    );

    pmtp_lerp u_lerp_m (
        .i_clk   (i_clk),
        .i_ctl   (mul_ctl),
        .i_bit   (quot[r_cnt]),
        .i_base  (r_prev_m),
        .i_diff  (pmtp_pkg::DIFF_W'(in_m) - pmtp_pkg::DIFF_W'(r_prev_m)),
        .o_value (lerp_m)
    );

endmodule

[hdl/pmtp_div.sv]
// Restoring divider, one quotient bit per step, MSB first.
module pmtp_div #(
    parameter int FACTOR_BITS = pmtp_pkg::FACTOR_BITS_DEF
) (
    input  logic                                 i_clk,
    input  pmtp_pkg::t_ser_ctl                   i_ctl,
    input  logic signed [pmtp_pkg::DIFF_W-1:0]   i_num,
    input  logic signed [pmtp_pkg::DIFF_W-1:0]   i_den,
    output logic        [FACTOR_BITS-1:0]        o_quot
);

    logic [pmtp_pkg::COORD_W-1:0] r_rem;
    logic [pmtp_pkg::COORD_W-1:0] r_den;
    logic [FACTOR_BITS-1:0]       r_q;
    logic                         r_zero;
    logic                         r_sat;

    logic [pmtp_pkg::REM_W-1:0]   n_trial;
    logic                         n_ge;

    always_comb begin
        n_trial = {r_rem, 1'b0};
        n_ge    = n_trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            // both stay below 2^32 whenever the loop result is used
            r_rem  <= i_num[pmtp_pkg::COORD_W-1:0];
            r_den  <= i_den[pmtp_pkg::COORD_W-1:0];
            r_q    <= '0;
            r_zero <= (i_den <= 0) || (i_num <= 0);
            r_sat  <= i_num >= i_den;
        end else if (i_ctl.step) begin
            r_rem <= n_ge ? pmtp_pkg::COORD_W'(n_trial - {1'b0, r_den})
                          : n_trial[pmtp_pkg::COORD_W-1:0];
            r_q   <= {r_q[FACTOR_BITS-2:0], n_ge};
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (r_sat) begin
            o_quot = '1;
        end else begin
            o_quot = r_q;
        end
    end

endmodule

[hdl/pmtp_lerp.sv]
// Bit-serial a1 + floor(f * d / 2^N), factor bits fed LSB first.
module pmtp_lerp (
    input  logic                                 i_clk,
    input  pmtp_pkg::t_ser_ctl                   i_ctl,
    input  logic                                 i_bit,
    input  logic signed [pmtp_pkg::COORD_W-1:0]  i_base,
    input  logic signed [pmtp_pkg::DIFF_W-1:0]   i_diff,
    output logic        [pmtp_pkg::COORD_W-1:0]  o_value
);

    logic signed [pmtp_pkg::COORD_W-1:0] r_base;
    logic signed [pmtp_pkg::DIFF_W-1:0]  r_diff;
    logic signed [pmtp_pkg::ACC_W-1:0]   r_acc;
    logic signed [pmtp_pkg::ACC_W-1:0]   n_sum;

    always_comb begin
        n_sum = r_acc + (i_bit ? pmtp_pkg::ACC_W'(r_diff) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_base <= i_base;
            r_diff <= i_diff;
            r_acc  <= '0;
        end else if (i_ctl.step) begin
            // arithmetic shift keeps floor rounding exact
            r_acc <= n_sum >>> 1;
        end
    end

    // result lies between the two end points, so 32 bits suffice
    assign o_value = r_base + r_acc[pmtp_pkg::COORD_W-1:0];

endmodule

[sim/tb_polyline_measure_to_point.sv]
`timescale 1ns / 1ps

// One vertex as it travels on the slave stream.
typedef struct packed {
    logic        last;
    logic [31:0] m;
    logic [31:0] y;
    logic [31:0] x;
} t_vertex;

// One location beat as it leaves on the master stream.
typedef struct packed {
    logic        found;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] m;
} t_located;

// Tracks the polyline walk in 64-bit arithmetic and keeps the locations
// still owed by the block, oldest first.
class measure_locator_sb;
    longint   target_m;
    bit       await_first;
    longint   first_m;
    longint   prev_x, prev_y, prev_m;
    bit       latched;
    longint   held_x, held_y, held_m;
    t_located owed_q[$];
    int       errors;
    int       checked;
    int       hits;

    function new();
        target_m    = 0;
        await_first = 1'b1;
        first_m     = 0;
        prev_x      = 0;
        prev_y      = 0;
        prev_m      = 0;
        latched     = 1'b0;
        held_x      = 0;
        held_y      = 0;
        held_m      = 0;
        errors      = 0;
        checked     = 0;
        hits        = 0;
    endfunction

    function void set_target(logic [31:0] t);
        target_m = longint'($signed(t));
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    // Q0.16 fraction of the way from m1 to m2 where t sits, truncated.
    function longint crossing_factor(longint m1, longint m2, longint t);
        longint num, den;
        num = t - m1;
        den = m2 - m1;
        if (den <= 0 || num <= 0)
            return 0;
        if (num >= den)
            return (longint'(1) <<< pmtp_pkg::FACTOR_BITS_DEF) - 1;
        return (num <<< pmtp_pkg::FACTOR_BITS_DEF) / den;
    endfunction

    // a1 + floor(f * (a2 - a1) / 2^16); arithmetic shift gives the floor
    function longint blend(longint a1, longint a2, longint f);
        return a1 + ((f * (a2 - a1)) >>> pmtp_pkg::FACTOR_BITS_DEF);
    endfunction

    function void note_vertex(t_vertex v);
        longint   x, y, m, f;
        t_located r;
        x = longint'($signed(v.x));
        y = longint'($signed(v.y));
        m = longint'($signed(v.m));
        if (await_first) begin
            first_m     = m;
            await_first = 1'b0;
        end else if (!latched && m > target_m) begin
            // first crossing only; later parts never overwrite it
            f       = crossing_factor(prev_m, m, target_m);
            held_x  = blend(prev_x, x, f);
            held_y  = blend(prev_y, y, f);
            held_m  = blend(prev_m, m, f);
            latched = 1'b1;
        end
        // previous vertex bridges part boundaries too
        prev_x = x;
        prev_y = y;
        prev_m = m;
        if (v.last) begin
            if (latched && target_m >= first_m && target_m <= m) begin
                r.found = 1'b1;
                r.x     = held_x[31:0];
                r.y     = held_y[31:0];
                r.m     = held_m[31:0];
            end else begin
                r = '0;
            end
            owed_q.push_back(r);
            await_first = 1'b1;
            latched     = 1'b0;
        end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(logic found, logic [95:0] data);
        t_located want;
        if (owed_q.size() == 0) begin
            $display("%0t: unexpected beat, expected none actual found=%0b data=%h",
                     $time, found, data);
            errors++;
            return;
        end
        want = owed_q.pop_front();
        checked++;
        if (want.found)
            hits++;
        if (found !== want.found) begin
            $display("%0t: found mismatch, expected %0b actual %0b", $time, want.found, found);
            errors++;
        end
        compare_field("out_x", want.x, data[31:0]);
        compare_field("out_y", want.y, data[63:32]);
        compare_field("out_measure", want.m, data[95:64]);
    endfunction
endclass

module tb_polyline_measure_to_point;

    localparam int FACTOR_BITS   = pmtp_pkg::FACTOR_BITS_DEF;
    // crossing vertex plus output load, with margin
    localparam int SETTLE_CYCLES = 2 * FACTOR_BITS + 10;
    localparam int RANDOM_ITEMS  = 650;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [31:0] M_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] M_MIN = 32'h8000_0000;
    localparam longint      L_MAX = 64'sd2147483647;
    localparam longint      L_MIN = -64'sd2147483648;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [pmtp_pkg::COORD_W-1:0]      i_cfg_data;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [pmtp_pkg::TDATA_W-1:0]      s_axis_tdata;   // x, y, measure
    logic                              s_axis_tlast;   // last_point
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [pmtp_pkg::TDATA_W-1:0]      m_axis_tdata;   // out_x, out_y, out_measure
    logic                              m_axis_tuser;   // found

    measure_locator_sb sb;
    t_vertex           poly_q[$];
    int                vertex_count  = 0;
    int                polyline_count = 0;
    int                setting_count = 0;
    int                cycle_count   = 0;
    bit                src_steady    = 1'b0;
    bit                rx_steady     = 1'b0;

    polyline_measure_to_point i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop for a hung block
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: random stall per beat, then hold tready until a beat goes.
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    function automatic logic [31:0] sat32(longint v);
        if (v > L_MAX)
            return M_MAX;
        if (v < L_MIN)
            return M_MIN;
        return v[31:0];
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return 32'($urandom_range(0, 2047)) - 32'd1024;
            1:       return $urandom_range(0, 1) ? M_MAX : M_MIN;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_target();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? M_MAX : M_MIN;
            1:       return M_MAX - 32'($urandom_range(0, 4096));
            2:       return M_MIN + 32'($urandom_range(0, 4096));
            3:       return 32'($urandom_range(0, 8191)) - 32'd4096;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] m,
                                       logic last);
        t_vertex v;
        v.x    = x;
        v.y    = y;
        v.m    = m;
        v.last = last;
        poly_q.push_back(v);
    endfunction

    // Mostly a measure run that climbs through the target (with equal steps,
    // an occasional backward jump at a part boundary, or a start above the
    // target); the rest is unordered noise.
    function automatic void build_polyline(longint t);
        int     len, back_at;
        longint smax, total, offset, mm;
        longint steps [0:15];
        poly_q.delete();
        if ($urandom_range(0, 9) < 7) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(2, 6);
            case ($urandom_range(0, 3))
                0:       smax = 16;
                1:       smax = 4096;
                2:       smax = 1 << 20;
                default: smax = 1 << 28;
            endcase
            back_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
            total   = 0;
            for (int i = 1; i < len; i++) begin
                steps[i] = ($urandom_range(0, 9) == 0) ? 0
                         : longint'($urandom_range(1, int'(smax)));
                if (i == back_at)
                    steps[i] = -steps[i];
                else
                    total += steps[i];
            end
            offset = longint'({$urandom, $urandom} >> 1) % (total + 1);
            mm = ($urandom_range(0, 9) == 0) ? t + longint'($urandom_range(1, 64))
                                             : t - offset;
            for (int i = 0; i < len; i++) begin
                if (i > 0)
                    mm += steps[i];
                add_vertex(rand_coord(), rand_coord(), sat32(mm), i == len - 1);
            end
        end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                add_vertex(rand_coord(), rand_coord(),
                           $urandom_range(0, 1) ? $urandom
                               : sat32(t + longint'($urandom_range(0, 512)) - 256),
                           i == len - 1);
        end
    endfunction

    // tvalid stays high across back-to-back beats; only a gap lowers it.
    task automatic send_vertex(t_vertex v);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v.m, v.y, v.x};
        s_axis_tlast  <= v.last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_vertex(v);
        vertex_count++;
    endtask

    task automatic send_polyline();
        foreach (poly_q[i])
            send_vertex(poly_q[i]);
        poly_q.delete();
        polyline_count++;
    endtask

    // Sender pauses until every owed location is back, then lets the
    // divider/multiplier finish anything still in flight.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // target is only rewritten with the block idle
    task automatic write_target(logic [31:0] t);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= t;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_target(t);
        setting_count++;
    endtask

    initial begin
        logic [31:0] tgt;
        int          random_end, phase_end;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: target at zero ---
        write_target(32'd0);
        // single vertex: never a crossing
        add_vertex(M_MAX, M_MIN, -32'sd5, 1'b1);
        send_polyline();
        // half-way crossing at full-scale coordinates
        add_vertex(32'd0, 32'd0, -32'sd256, 1'b0);
        add_vertex(M_MAX, M_MIN, 32'sd256, 1'b1);
        send_polyline();
        // equal measures, first vertex already past the target
        add_vertex(32'd1, 32'd2, 32'sd100, 1'b0);
        add_vertex(32'd3, 32'd4, 32'sd100, 1'b1);
        send_polyline();
        // target lands exactly on a vertex measure
        add_vertex(32'd10, 32'd10, -32'sd100, 1'b0);
        add_vertex(32'd20, 32'd20, 32'sd0, 1'b0);
        add_vertex(32'd30, 32'd30, 32'sd100, 1'b1);
        send_polyline();
        // second part crosses again: first crossing must stick
        add_vertex(-32'sd1000, 32'sd5000, -32'sd50, 1'b0);
        add_vertex(32'sd1000, -32'sd5000, 32'sd50, 1'b0);
        add_vertex(32'd7, 32'd7, -32'sd20, 1'b0);
        add_vertex(32'd9, 32'd9, 32'sd80, 1'b1);
        send_polyline();
        // crossing latched but last measure falls short
        add_vertex(32'd11, 32'd12, -32'sd10, 1'b0);
        add_vertex(32'd13, 32'd14, 32'sd10, 1'b0);
        add_vertex(32'd15, 32'd16, -32'sd5, 1'b1);
        send_polyline();

        // --- directed: most positive target, nothing can exceed it ---
        write_target(M_MAX);
        add_vertex(M_MIN, M_MIN, M_MIN, 1'b0);
        add_vertex(M_MAX, M_MAX, M_MAX, 1'b1);
        send_polyline();
        add_vertex(32'd5, 32'd5, -32'sd1, 1'b0);
        add_vertex(32'd6, 32'd6, M_MAX, 1'b1);
        send_polyline();

        // --- directed: most negative target ---
        write_target(M_MIN);
        add_vertex(32'h1234_5678, 32'h8765_4321, M_MIN, 1'b0);
        add_vertex(32'h0F0F_0F0F, 32'hF0F0_F0F0, M_MAX, 1'b1);
        send_polyline();
        add_vertex(32'hDEAD_BEEF, 32'h0000_FFFF, -32'sd1, 1'b0);
        add_vertex(32'h5555_5555, 32'hAAAA_AAAA, M_MAX, 1'b1);
        send_polyline();

        // --- random phases, one target setting each ---
        random_end = vertex_count + RANDOM_ITEMS;
        while (vertex_count < random_end) begin
            tgt = pick_target();
            write_target(tgt);
            src_steady = ($urandom_range(0, 3) == 0);
            rx_steady  = ($urandom_range(0, 3) == 0);
            phase_end  = vertex_count + $urandom_range(20, 50);
            while (vertex_count < phase_end) begin
                build_polyline(longint'($signed(tgt)));
                send_polyline();
            end
        end

        settle();
        $display("Walked %0d vertices in %0d polylines under %0d target settings.",
                 vertex_count, polyline_count, setting_count);
        $display("Checked %0d locations (%0d located, %0d not), %0d mismatches.",
                 sb.checked, sb.hits, sb.checked - sb.hits, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
hdl/pmtp_pkg.sv
hdl/pmtp_div.sv
hdl/pmtp_lerp.sv
hdl/polyline_measure_to_point.sv
sim/tb_polyline_measure_to_point.sv
